// ===== hdl/lzw_variable_width_compressor_assert.svh =====
// Assertion macros used by the port-level checker
`ifndef LZW_VARIABLE_WIDTH_COMPRESSOR_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_COMPRESSOR_ASSERT_SVH

// Checked only while out of reset
`define LZW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lzw assertion failed");

// Checked at every edge, reset included
`define LZW_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lzw assertion failed");

`endif

// ===== hdl/lzw_pkg.sv =====
// Shared constants, types and state codes of the LZW compressor
`timescale 1ns / 1ps
`default_nettype none
package lzw_pkg;
  localparam int MaxCodeBits = 12;
  localparam int HashSlots   = 8192;
  localparam int AlphaLast   = 26;
  localparam int InitWidth   = 5;
  localparam int FirstFree   = 27;
  localparam int MaxOut      = 4;
  localparam int OutqDepth   = 4;

  localparam int SymW      = 5;
  localparam int CodeW     = MaxCodeBits;
  localparam int KeyW      = CodeW + SymW;
  localparam int HashW     = $clog2(HashSlots);
  localparam int NfcW      = CodeW + 1;
  localparam int WidW      = $clog2(MaxCodeBits + 1);
  localparam int AccW      = MaxCodeBits + 8;
  localparam int CntW      = $clog2(AccW + 1);
  localparam int EntryW    = 1 + KeyW + CodeW;
  localparam int HashShift = 7;
  localparam int ProdW     = HashW + HashShift;
  localparam int IdxW      = $clog2(MaxOut + 2);
  localparam int OqPtrW    = $clog2(OutqDepth);
  localparam int OqCntW    = $clog2(OutqDepth + 1);

  localparam logic [ProdW-1:0] HashK = ProdW'(64'd2654435761);

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            last;
  } item_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       fin;
  } out_req_t;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_HELD   = 13'b0000000000100,
    S_START  = 13'b0000000001000,
    S_ADDR   = 13'b0000000010000,
    S_READ   = 13'b0000000100000,
    S_CHECK  = 13'b0000001000000,
    S_EMIT   = 13'b0000010000000,
    S_DRAIN  = 13'b0000100000000,
    S_INSERT = 13'b0001000000000,
    S_LAST   = 13'b0010000000000,
    S_FEMIT  = 13'b0100000000000,
    S_FDRAIN = 13'b1000000000000
  } state_e;
endpackage
`default_nettype wire

// ===== hdl/lzw_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none
module lzw_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lzw_front.sv =====
// Input queue: takes symbol requests and folds out-of-alphabet symbols to '-'
`timescale 1ns / 1ps
`default_nettype none
module lzw_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  output      logic                       full_o,
  input  wire logic [lzw_pkg::SymW-1:0]   symbol_i,
  input  wire logic                       end_of_text_i,
  input  wire logic                       block_i,
  output      logic                       item_valid_o,
  output      lzw_pkg::item_t             item_o,
  input  wire logic                       item_pop_i
);
  import lzw_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       acc, pop;
  item_t      in_item;

  assign full_o       = (cnt_q == 2'd2) || block_i;
  assign acc          = push_i && !full_o;
  assign item_valid_o = cnt_q != 2'd0;
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    in_item.sym  = (symbol_i > SymW'(AlphaLast)) ? '0 : symbol_i;
    in_item.last = end_of_text_i;
    wr_d  = acc ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, acc} - {1'b0, pop};
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_q[wr_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lzw_outq.sv =====
// Output byte queue between the dictionary engine and the result port
`timescale 1ns / 1ps
`default_nettype none
module lzw_outq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lzw_pkg::out_req_t req_i,
  output      logic              full_o,
  output      logic              empty_o,
  input  wire logic              pop_i,
  output      logic [7:0]        out_byte_o,
  output      logic              final_byte_o
);
  import lzw_pkg::*;

  logic [8:0]        mem_q [OutqDepth];
  logic [OqPtrW-1:0] wr_q, rd_q;
  logic [OqCntW-1:0] cnt_q;
  logic              wr, rd;

  assign full_o  = cnt_q == OqCntW'(OutqDepth);
  assign empty_o = cnt_q == '0;
  assign wr      = req_i.push && !full_o;
  assign rd      = pop_i && !empty_o;
  assign {out_byte_o, final_byte_o} = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_q] <= {req_i.data, req_i.fin};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wr_q <= wr_q + 1'b1;
      if (rd) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + OqCntW'(wr) - OqCntW'(rd);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lzw_core.sv =====
// Dictionary engine: hashed probe, insert, code packing and byte output
`timescale 1ns / 1ps
`default_nettype none
module lzw_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 item_valid_i,
  input  wire lzw_pkg::item_t       item_i,
  output      logic                 item_pop_o,
  output      logic                 clearing_o,
  output      lzw_pkg::out_req_t    req_o,
  input  wire logic                 outq_full_i
);
  import lzw_pkg::*;

  state_e              state_q, state_d;
  logic [SymW-1:0]     sym_q, sym_d;
  logic                last_q, last_d;
  logic [CodeW-1:0]    prefix_q, prefix_d;
  logic                pv_q, pv_d;
  logic [NfcW-1:0]     nfc_q, nfc_d;
  logic [WidW-1:0]     wid_q, wid_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [HashW-1:0]    idx_q, idx_d;
  logic [HashW-1:0]    n_q, n_d;
  logic                free_ok_q, free_ok_d;
  logic [HashW-1:0]    free_idx_q, free_idx_d;
  logic [7:0]          held_q, held_d;
  logic                held_v_q, held_v_d;
  logic [IdxW-1:0]     bidx_q, bidx_d;
  logic [HashW-1:0]    clr_q, clr_d;

  logic                we, re;
  logic [HashW-1:0]    waddr;
  logic [EntryW-1:0]   wdata, rdata;
  logic [KeyW-1:0]     key;
  logic [CodeW-1:0]    mask;
  logic                hold_slot, can_push;
  logic [NfcW-1:0]     nfc_inc;
  logic                rd_vld;
  logic [KeyW-1:0]     rd_key;
  logic [CodeW-1:0]    rd_code;

  lzw_ram #(.Width(EntryW), .Depth(HashSlots)) u_dict (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign key        = {prefix_q, sym_q};
  assign mask       = ~({CodeW{1'b1}} << wid_q);
  assign hold_slot  = bidx_q == IdxW'(MaxOut);
  assign can_push   = hold_slot || !outq_full_i;
  assign nfc_inc    = nfc_q + 1'b1;
  assign {rd_vld, rd_key, rd_code} = rdata;
  assign clearing_o = state_q == S_CLEAR;

  always_comb begin
    state_d    = state_q;
    sym_d      = sym_q;
    last_d     = last_q;
    prefix_d   = prefix_q;
    pv_d       = pv_q;
    nfc_d      = nfc_q;
    wid_d      = wid_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    prod_d     = prod_q;
    idx_d      = idx_q;
    n_d        = n_q;
    free_ok_d  = free_ok_q;
    free_idx_d = free_idx_q;
    held_d     = held_q;
    held_v_d   = held_v_q;
    bidx_d     = bidx_q;
    clr_d      = clr_q;
    item_pop_o = 1'b0;
    req_o      = '0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = clr_q;
    wdata      = '0;

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == HashW'(HashSlots - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          sym_d      = item_i.sym;
          last_d     = item_i.last;
          bidx_d     = '0;
          state_d    = held_v_q ? S_HELD : S_START;
        end
      end
      S_HELD: begin
        if (!outq_full_i) begin
          req_o    = '{push: 1'b1, data: held_q, fin: 1'b1};
          held_v_d = 1'b0;
          bidx_d   = IdxW'(1);
          state_d  = S_START;
        end
      end
      S_START: begin
        if (!pv_q) begin
          prefix_d = CodeW'(sym_q);
          pv_d     = 1'b1;
          state_d  = S_LAST;
        end else begin
          prod_d  = ProdW'(ProdW'(key) * HashK);
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        idx_d   = prod_q[ProdW-1:HashShift];
        n_d     = '0;
        state_d = S_READ;
      end
      S_READ: begin
        re      = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_vld) begin
          free_ok_d  = 1'b1;
          free_idx_d = idx_q;
          state_d    = S_EMIT;
        end else if (rd_key == key) begin
          prefix_d = rd_code;
          state_d  = S_LAST;
        end else if (n_q == HashW'(HashSlots - 1)) begin
          // table full, nowhere to insert
          free_ok_d = 1'b0;
          state_d   = S_EMIT;
        end else begin
          idx_d   = idx_q + 1'b1;
          n_d     = n_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_EMIT, S_FEMIT: begin
        acc_d   = acc_q | (AccW'(prefix_q & mask) << cnt_q);
        cnt_d   = cnt_q + CntW'(wid_q);
        state_d = (state_q == S_EMIT) ? S_DRAIN : S_FDRAIN;
      end
      S_DRAIN: begin
        if (cnt_q >= CntW'(8)) begin
          if (can_push) begin
            if (hold_slot) begin
              held_d   = acc_q[7:0];
              held_v_d = 1'b1;
            end else begin
              req_o = '{push: 1'b1, data: acc_q[7:0], fin: 1'b0};
            end
            bidx_d = bidx_q + 1'b1;
            acc_d  = acc_q >> 8;
            cnt_d  = cnt_q - CntW'(8);
          end
        end else begin
          state_d = S_INSERT;
        end
      end
      S_INSERT: begin
        if (!nfc_q[CodeW] && free_ok_q) begin
          we    = 1'b1;
          waddr = free_idx_q;
          wdata = {1'b1, key, nfc_q[CodeW-1:0]};
          nfc_d = nfc_inc;
          if ({1'b0, nfc_inc} >= ((NfcW+1)'(1) << wid_q) && wid_q < WidW'(MaxCodeBits)) begin
            wid_d = wid_q + 1'b1;
          end
        end
        prefix_d = CodeW'(sym_q);
        state_d  = S_LAST;
      end
      S_LAST: begin
        state_d = last_q ? S_FEMIT : S_IDLE;
      end
      S_FDRAIN: begin
        // last byte is the one that leaves no bits behind; partial byte is zero padded
        if (can_push) begin
          if (hold_slot) begin
            held_d   = acc_q[7:0];
            held_v_d = 1'b1;
          end else begin
            req_o = '{push: 1'b1, data: acc_q[7:0], fin: cnt_q <= CntW'(8)};
          end
          bidx_d = bidx_q + 1'b1;
          if (cnt_q > CntW'(8)) begin
            acc_d = acc_q >> 8;
            cnt_d = cnt_q - CntW'(8);
          end else begin
            acc_d    = '0;
            cnt_d    = '0;
            prefix_d = '0;
            pv_d     = 1'b0;
            nfc_d    = NfcW'(FirstFree);
            wid_d    = WidW'(InitWidth);
            clr_d    = '0;
            state_d  = S_CLEAR;
          end
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    last_q     <= last_d;
    prod_q     <= prod_d;
    idx_q      <= idx_d;
    n_q        <= n_d;
    free_idx_q <= free_idx_d;
    held_q     <= held_d;
    free_ok_q  <= free_ok_d;
    bidx_q     <= bidx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      prefix_q <= '0;
      pv_q     <= 1'b0;
      nfc_q    <= NfcW'(FirstFree);
      wid_q    <= WidW'(InitWidth);
      acc_q    <= '0;
      cnt_q    <= '0;
      held_v_q <= 1'b0;
      clr_q    <= '0;
    end else begin
      state_q  <= state_d;
      prefix_q <= prefix_d;
      pv_q     <= pv_d;
      nfc_q    <= nfc_d;
      wid_q    <= wid_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      held_v_q <= held_v_d;
      clr_q    <= clr_d;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lzw_variable_width_compressor.sv =====
// LZW compressor with growing code width: top level
// One symbol request goes in per push; packed code bytes come out LSB first, the
// last byte of a text flagged by final_byte_o. A symbol that extends the current
// match steps through the start, hash address, read and check states, and the
// linear probe repeats read and check for each extra dictionary slot it visits;
// a miss adds the emit, drain and insert states, and the drain can stall on a
// full output queue. Probing is bound by the single read port of the 8192-entry
// hashed dictionary memory. After reset and after every end-of-text symbol the
// dictionary is cleared one slot per cycle, during which full_o stays high.
// Requests queue on both sides, so input and output stall independently.
`timescale 1ns / 1ps
`default_nettype none
module lzw_variable_width_compressor (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  output      logic                     full_o,
  input  wire logic [lzw_pkg::SymW-1:0] symbol_i,
  input  wire logic                     end_of_text_i,
  output      logic                     empty_o,
  input  wire logic                     pop_i,
  output      logic [7:0]               out_byte_o,
  output      logic                     final_byte_o
);
  import lzw_pkg::*;

  logic     item_valid, item_pop, clearing, outq_full;
  item_t    item;
  out_req_t req;

  lzw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .symbol_i      (symbol_i),
    .end_of_text_i (end_of_text_i),
    .block_i       (clearing),
    .item_valid_o  (item_valid),
    .item_o        (item),
    .item_pop_i    (item_pop)
  );

  lzw_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .clearing_o   (clearing),
    .req_o        (req),
    .outq_full_i  (outq_full)
  );

  lzw_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .full_o       (outq_full),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_byte_o   (out_byte_o),
    .final_byte_o (final_byte_o)
  );
endmodule
`default_nettype wire

// ===== hdl/lzw_checker.sv =====
// Port-level checker for the LZW compressor, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "lzw_variable_width_compressor_assert.svh"
module lzw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full_o,
  input wire logic       empty_o,
  input wire logic       pop_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       final_byte_o
);
  // dictionary clear runs right after reset, so no request is taken yet
  `LZW_ASSERT_ALWAYS(a_clear_after_reset, clk_i, $rose(rst_ni) |-> full_o)
  // nothing can be waiting right after reset
  `LZW_ASSERT_ALWAYS(a_empty_after_reset, clk_i, $rose(rst_ni) |-> empty_o)
  // a waiting byte holds until popped
  `LZW_ASSERT(a_out_hold, clk_i, rst_ni, !empty_o && !pop_i |=> !empty_o && $stable(out_byte_o) && $stable(final_byte_o))
endmodule

bind lzw_variable_width_compressor lzw_checker u_lzw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .full_o       (full_o),
  .empty_o      (empty_o),
  .pop_i        (pop_i),
  .out_byte_o   (out_byte_o),
  .final_byte_o (final_byte_o)
);
`default_nettype wire

// ===== tb/lzw_variable_width_compressor_checker.sv =====
// Byte stream predictor and scoreboard for the LZW compressor
`timescale 1ns / 1ps
module lzw_variable_width_compressor_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic                     full_i,
  input  logic [lzw_pkg::SymW-1:0] symbol_i,
  input  logic                     end_of_text_i,
  input  logic                     empty_i,
  input  logic                     pop_i,
  input  logic [7:0]               out_byte_i,
  input  logic                     final_byte_i,
  output int                       errors_o,
  output int                       pending_o,
  output int                       bytes_o
);
  import lzw_pkg::*;

  int unsigned dict_code [int unsigned];
  int unsigned cur_prefix;
  bit          prefix_ok;
  int unsigned free_code;
  int unsigned code_bits;
  int unsigned acc_bits;
  int unsigned acc_cnt;
  bit          held_ok;
  logic [7:0]  held_byte;

  logic [7:0]  step_bytes [8];
  bit          step_fin [8];
  int          step_n;

  logic [7:0]  want_byte [$];
  bit          want_fin [$];

  task automatic restart_text();
    dict_code.delete();
    cur_prefix = 0;
    prefix_ok  = 0;
    free_code  = FirstFree;
    code_bits  = InitWidth;
    acc_bits   = 0;
    acc_cnt    = 0;
  endtask

  task automatic add_byte(logic [7:0] b, bit fin);
    if (step_n < 8) begin
      step_bytes[step_n] = b;
      step_fin[step_n]   = fin;
      step_n++;
    end
  endtask

  task automatic pack_code(int unsigned code);
    acc_bits |= (code & ((1 << code_bits) - 1)) << acc_cnt;
    acc_cnt += code_bits;
    while (acc_cnt >= 8) begin
      add_byte(acc_bits[7:0], 0);
      acc_bits >>= 8;
      acc_cnt -= 8;
    end
  endtask

  task automatic compress_symbol(logic [SymW-1:0] sym_in, bit last);
    int unsigned s;
    int unsigned key;
    int          k;
    s = (sym_in > AlphaLast) ? 0 : sym_in;
    step_n = 0;
    if (held_ok) begin
      add_byte(held_byte, 1);
      held_ok = 0;
    end
    if (!prefix_ok) begin
      cur_prefix = s;
      prefix_ok  = 1;
    end else begin
      key = (cur_prefix << 5) | s;
      if (dict_code.exists(key)) begin
        cur_prefix = dict_code[key];
      end else begin
        pack_code(cur_prefix);
        // table never fills before the code space does at this size
        if (free_code < (1 << MaxCodeBits) && dict_code.num() < HashSlots) begin
          dict_code[key] = free_code;
          free_code++;
          if (free_code >= (1 << code_bits) && code_bits < MaxCodeBits) code_bits++;
        end
        cur_prefix = s;
      end
    end
    if (last) begin
      pack_code(cur_prefix);
      if (acc_cnt > 0) add_byte(acc_bits[7:0], 0);
      if (step_n > 0) step_fin[step_n-1] = 1;
      restart_text();
    end
    if (step_n > MaxOut) begin
      held_ok   = 1;
      held_byte = step_bytes[MaxOut];
      step_n    = MaxOut;
    end
    for (k = 0; k < step_n; k++) begin
      want_byte.push_back(step_bytes[k]);
      want_fin.push_back(step_fin[k]);
    end
  endtask

  task automatic report(string what, int got, int exp);
    $display("ERROR t=%0t byte %0d: %s got %0h expected %0h", $time, bytes_o, what, got, exp);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_text();
      held_ok = 0;
      want_byte.delete();
      want_fin.delete();
      errors_o  = 0;
      bytes_o   = 0;
      pending_o = 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (want_byte.size() == 0) begin
          report("unexpected byte", out_byte_i, 0);
        end else begin
          if (out_byte_i !== want_byte[0]) report("out_byte", out_byte_i, want_byte[0]);
          if (final_byte_i !== want_fin[0]) report("final_byte", final_byte_i, want_fin[0]);
          void'(want_byte.pop_front());
          void'(want_fin.pop_front());
        end
        bytes_o++;
      end
      if (push_i && !full_i) compress_symbol(symbol_i, end_of_text_i);
      pending_o = want_byte.size();
    end
  end
endmodule

// ===== tb/lzw_variable_width_compressor_tb.sv =====
// Top of the LZW compressor testbench: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module lzw_variable_width_compressor_tb;
  import lzw_pkg::*;

  localparam logic [SymW-1:0] SymDash = 5'd0;
  localparam logic [SymW-1:0] SymA    = 5'd1;
  localparam logic [SymW-1:0] SymB    = 5'd2;
  localparam logic [SymW-1:0] SymZ    = 5'd26;
  localparam logic [SymW-1:0] SymBad  = 5'd27;
  localparam logic [SymW-1:0] SymMax  = 5'd31;
  localparam int CycleLimit = 5000000;

  logic            clk_i = 0;
  logic            rst_ni = 0;
  logic            push_i = 0;
  logic [SymW-1:0] symbol_i = '0;
  logic            end_of_text_i = 0;
  logic            pop_i = 0;
  logic            full_o, empty_o, final_byte_o;
  logic [7:0]      out_byte_o;
  int              errors, pending, bytes_seen;
  int              cycles = 0;
  int              sent = 0;
  int              texts = 0;
  bit              quiet = 0;

  lzw_variable_width_compressor u_dut (
    .clk_i, .rst_ni, .push_i, .full_o, .symbol_i, .end_of_text_i,
    .empty_o, .pop_i, .out_byte_o, .final_byte_o
  );

  lzw_variable_width_compressor_checker u_chk (
    .clk_i, .rst_ni, .push_i, .full_i(full_o), .symbol_i, .end_of_text_i,
    .empty_i(empty_o), .pop_i, .out_byte_i(out_byte_o), .final_byte_i(final_byte_o),
    .errors_o(errors), .pending_o(pending), .bytes_o(bytes_seen)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("lzw_variable_width_compressor: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) pop_i <= quiet || ($urandom_range(99) >= 10);
  end

  // one symbol request; idles first at random, returns once accepted
  task automatic send_symbol(logic [SymW-1:0] s, bit last);
    @(negedge clk_i);
    if (!quiet && $urandom_range(99) < 10) begin
      push_i <= 0;
      repeat ($urandom_range(5, 1)) @(negedge clk_i);
    end
    push_i        <= 1;
    symbol_i      <= s;
    end_of_text_i <= last;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    sent++;
    if (last) texts++;
  endtask

  task automatic random_text(int len, int spread);
    int i;
    logic [SymW-1:0] s;
    for (i = 0; i < len; i++) begin
      // narrow alphabet gives long dictionary matches; rare noise symbols
      if ($urandom_range(99) < 5) s = SymW'($urandom_range(31));
      else s = SymW'($urandom_range(spread));
      send_symbol(s, i == len - 1);
    end
  endtask

  initial begin
    int i;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: single-symbol text, alphabet edges, out-of-range symbols
    send_symbol(SymZ, 1);
    send_symbol(SymDash, 0);
    send_symbol(SymZ, 0);
    send_symbol(SymBad, 0);
    send_symbol(SymMax, 0);
    send_symbol(SymDash, 1);
    for (i = 0; i < 14; i++) send_symbol((i % 2) ? SymB : SymA, i == 13);

    @(negedge clk_i);
    push_i <= 0;
    while (pending != 0) @(negedge clk_i);

    random_text(12, 26);
    quiet = 1;
    random_text(60, 3);
    quiet = 0;
    random_text(150, 26);
    while (sent < 350) random_text($urandom_range(40, 2), $urandom_range(26, 1));
    // every random text ends with an end-of-text symbol, so no text is left open
    @(negedge clk_i);
    push_i <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("sent %0d symbols in %0d texts, checked %0d output bytes",
             sent, texts, bytes_seen);
    if (errors == 0) begin
      $display("lzw_variable_width_compressor: match");
    end else begin
      $display("lzw_variable_width_compressor: mismatch");
    end
    $finish;
  end
endmodule
